// File: hw/rtl/assert_macros.svh
// assertion macros for the pulse window statistics block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PWS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define PWS_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define PWS_ASSERT(lbl, prop)
`define PWS_NEVER(lbl, cond)
`endif
`endif

// File: hw/rtl/pws_pkg.sv
// shared types and constants of the pulse window statistics block
`default_nettype none
package pws_pkg;
  localparam int MAX_WINDOW = 4096;
  localparam int K_W        = $clog2(MAX_WINDOW);
  localparam int IDX_W      = K_W + 1;
  localparam int K2_W       = 2 * K_W;
  localparam int SUM_W      = 28;
  localparam int W1_W       = 41;
  localparam int W2_W       = 53;
  localparam int NUM_W      = 62;
  localparam int DEN_W      = 28;
  localparam int ROOT_W     = 31;
  localparam int M8_W       = 52;
  localparam int E2_W       = 54;
  localparam int MCSQ_W     = 54;

  typedef struct packed {
    logic accept;
    logic sel_e;
    logic div_start;
    logic latch_m;
    logic latch_e;
    logic root_start;
    logic latch_root;
    logic emit;
  } pws_cmd_t;

  typedef struct packed {
    logic zero;
    logic div_busy;
    logic div_done;
    logic root_done;
  } pws_status_t;

  typedef struct packed {
    logic [23:0]        spread;
    logic signed [24:0] mean;
    logic signed [15:0] after_max;
    logic signed [15:0] before_max;
    logic [15:0]        max_pos;
    logic signed [15:0] max_val;
    logic [15:0]        min_pos;
    logic signed [15:0] min_val;
    logic signed [27:0] area;
    logic               zero;
  } pws_result_t;
endpackage
`default_nettype wire

// File: hw/rtl/pws_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module pws_divider (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [pws_pkg::NUM_W-1:0] num_i,
  input  wire logic [pws_pkg::DEN_W-1:0] den_i,
  input  wire logic                      neg_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [pws_pkg::NUM_W-1:0]      quot_o,
  output logic                           neg_o
);
  import pws_pkg::*;
  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d, neg_q;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             fits;

  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = (rem_sh >= {1'b0, den_q});

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NUM_W-2:0], fits};
      rem_d = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
      neg_q <= neg_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = num_q;
  assign neg_o  = neg_q;
endmodule
`default_nettype wire

// File: hw/rtl/pws_isqrt.sv
// digit-by-digit integer square root, one result bit per cycle
`default_nettype none
module pws_isqrt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [pws_pkg::NUM_W-1:0] val_i,
  output logic                           done_o,
  output logic [pws_pkg::ROOT_W-1:0]     root_o
);
  import pws_pkg::*;
  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 2;

  logic [NUM_W-1:0]  val_q, val_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [REM_W+1:0]  rem_sh, trial, rem_sub;
  logic              fits;

  assign rem_sh  = {rem_q, val_q[NUM_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign rem_sub = rem_sh - trial;
  assign fits    = (rem_sh >= trial);

  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      val_d  = val_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d  = {val_q[NUM_W-3:0], 2'b00};
      rem_d  = fits ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_d = {root_q[ROOT_W-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(ROOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

// File: hw/rtl/pws_datapath.sv
// window accumulators, end-of-window arithmetic and result register
`default_nettype none
module pws_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [15:0]          cfg_wdata_i,
  input  wire logic signed [15:0]   sample_i,
  input  wire logic [15:0]          position_i,
  input  wire logic                 first_i,
  input  wire pws_pkg::pws_cmd_t    cmd_i,
  output pws_pkg::pws_status_t      status_o,
  output pws_pkg::pws_result_t      result_o
);
  import pws_pkg::*;

  logic [15:0]              scale_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [W1_W-1:0]   w1_q;
  logic signed [W2_W-1:0]   w2_q;
  logic signed [15:0]       low_q, high_q, before_q, after_q, prev_q;
  logic [15:0]              lowp_q, highp_q, start_q;
  logic                     pend_q;
  logic [IDX_W-1:0]         idx_q;
  logic [K2_W-1:0]          k2_q;

  // base values: a first flag restarts from a cleared window
  logic signed [SUM_W-1:0]  b_sum;
  logic signed [W1_W-1:0]   b_w1;
  logic signed [W2_W-1:0]   b_w2;
  logic signed [15:0]       b_low, b_high, b_before, b_after, b_prev;
  logic [15:0]              b_lowp, b_highp, b_start;
  logic                     b_pend;
  logic [IDX_W-1:0]         b_idx;
  logic [K2_W-1:0]          b_k2;
  logic [K_W-1:0]           k;
  logic                     k_zero, take;
  logic signed [28:0]       prod1;
  logic signed [40:0]       prod2;

  always_comb begin
    if (first_i) begin
      b_sum = '0; b_w1 = '0; b_w2 = '0;
      b_low = 16'sh7FFF; b_high = -16'sh8000;
      b_lowp = '0; b_highp = '0; b_before = '0; b_after = '0;
      b_pend = 1'b0; b_prev = '0; b_idx = '0; b_k2 = '0; b_start = '0;
    end else begin
      b_sum = sum_q; b_w1 = w1_q; b_w2 = w2_q;
      b_low = low_q; b_high = high_q;
      b_lowp = lowp_q; b_highp = highp_q; b_before = before_q; b_after = after_q;
      b_pend = pend_q; b_prev = prev_q; b_idx = idx_q; b_k2 = k2_q; b_start = start_q;
    end
  end

  assign k      = b_idx[K_W-1:0];
  assign k_zero = (b_idx == '0);
  assign take   = cmd_i.accept && !b_idx[IDX_W-1];
  assign prod1  = $signed({1'b0, k}) * sample_i;
  assign prod2  = $signed({1'b0, b_k2}) * sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0; w1_q <= '0; w2_q <= '0;
      low_q <= 16'sh7FFF; high_q <= -16'sh8000;
      lowp_q <= '0; highp_q <= '0; before_q <= '0; after_q <= '0;
      pend_q <= 1'b0; prev_q <= '0; idx_q <= '0; k2_q <= '0; start_q <= '0;
    end else if (cmd_i.emit) begin
      sum_q <= '0; w1_q <= '0; w2_q <= '0;
      low_q <= 16'sh7FFF; high_q <= -16'sh8000;
      lowp_q <= '0; highp_q <= '0; before_q <= '0; after_q <= '0;
      pend_q <= 1'b0; prev_q <= '0; idx_q <= '0; k2_q <= '0; start_q <= '0;
    end else if (take) begin
      sum_q   <= b_sum + SUM_W'(sample_i);
      w1_q    <= b_w1 + W1_W'(prod1);
      w2_q    <= b_w2 + W2_W'(prod2);
      start_q <= k_zero ? position_i : b_start;
      if (k_zero || sample_i < b_low) begin
        low_q  <= sample_i;
        lowp_q <= position_i;
      end else begin
        low_q  <= b_low;
        lowp_q <= b_lowp;
      end
      if (k_zero || sample_i > b_high) begin
        high_q   <= sample_i;
        highp_q  <= position_i;
        before_q <= k_zero ? 16'sd0 : b_prev;
        after_q  <= '0;
        pend_q   <= 1'b1;
      end else begin
        high_q   <= b_high;
        highp_q  <= b_highp;
        before_q <= b_before;
        after_q  <= b_pend ? sample_i : b_after;
        pend_q   <= 1'b0;
      end
      prev_q <= sample_i;
      idx_q  <= b_idx + 1'b1;
      k2_q   <= b_k2 + K2_W'({k, 1'b1});
    end
  end

  // divider operands: round(n / S) as (|n| + |S|/2) / |S| with sign
  logic signed [NUM_W-1:0] num_s;
  logic [NUM_W-1:0]        num_mag;
  logic [DEN_W-1:0]        s_mag;
  logic                    s_neg;
  logic [NUM_W-1:0]        div_q;
  logic                    div_neg, div_done, div_busy;

  assign num_s   = cmd_i.sel_e ? {{(NUM_W-W2_W-8){w2_q[W2_W-1]}}, w2_q, 8'b0}
                               : {{(NUM_W-W1_W-8){w1_q[W1_W-1]}}, w1_q, 8'b0};
  assign num_mag = num_s[NUM_W-1] ? -num_s : num_s;
  assign s_neg   = sum_q[SUM_W-1];
  assign s_mag   = s_neg ? -sum_q : sum_q;

  pws_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_mag + NUM_W'(s_mag >> 1)),
    .den_i   (s_mag),
    .neg_i   (num_s[NUM_W-1] ^ s_neg),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_q),
    .neg_o   (div_neg)
  );

  logic signed [M8_W-1:0] m8_q;
  logic [26:0]            mc_mag_q;
  logic [MCSQ_W-1:0]      mc_sq_q;
  logic signed [E2_W-1:0] e2_q;
  logic [52:0]            e2_mag;
  logic signed [NUM_W-1:0] var_s;
  logic [NUM_W-1:0]       var_mag;
  logic [ROOT_W-1:0]      root;
  logic                   root_done;
  logic [23:0]            spread_q;

  assign e2_mag  = (div_q > (NUM_W'(1) << 52)) ? (53'd1 << 52) : div_q[52:0];
  assign var_s   = {e2_q, 8'b0} - NUM_W'(mc_sq_q);
  assign var_mag = var_s[NUM_W-1] ? -var_s : var_s;

  always_ff @(posedge clk_i) begin
    mc_sq_q <= mc_mag_q * mc_mag_q;
    if (cmd_i.latch_m) begin
      m8_q     <= div_neg ? -div_q[M8_W-1:0] : div_q[M8_W-1:0];
      mc_mag_q <= (div_q > (NUM_W'(1) << 26)) ? (27'd1 << 26) : div_q[26:0];
    end
    if (cmd_i.latch_e) begin
      e2_q <= div_neg ? -$signed({1'b0, e2_mag}) : $signed({1'b0, e2_mag});
    end
    if (cmd_i.latch_root) begin
      spread_q <= (root > ROOT_W'(24'hFFFFFF)) ? 24'hFFFFFF : root[23:0];
    end
  end

  pws_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.root_start),
    .val_i   (var_mag),
    .done_o  (root_done),
    .root_o  (root)
  );

  // area and centroid are formed as the result is loaded
  logic [43:0]        area_p;
  logic [28:0]        area_mag;
  logic [52:0]        mt;
  logic               mt_hi, mt_lo;
  logic signed [24:0] mean;
  logic               zero;

  assign zero     = (sum_q == '0);
  assign area_p   = s_mag * scale_q;
  assign area_mag = s_neg ? 29'((area_p + 44'd65535) >> 16) : 29'(area_p >> 16);
  assign mt       = {21'b0, start_q, 8'b0} + {m8_q[M8_W-1], m8_q};
  assign mt_hi    = !mt[52] && (mt[51:24] != '0);
  assign mt_lo    = mt[52] && (mt[51:24] != '1);
  assign mean     = mt_hi ? 25'sh0FFFFFF : (mt_lo ? -25'sh1000000 : mt[24:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_o.area       <= s_neg ? -area_mag[27:0] : area_mag[27:0];
      result_o.min_val    <= low_q;
      result_o.min_pos    <= lowp_q;
      result_o.max_val    <= high_q;
      result_o.max_pos    <= highp_q;
      result_o.before_max <= before_q;
      result_o.after_max  <= after_q;
      result_o.mean       <= zero ? 25'sd0 : mean;
      result_o.spread     <= zero ? 24'd0 : spread_q;
      result_o.zero       <= zero;
    end
  end

  assign status_o.zero      = zero;
  assign status_o.div_busy  = div_busy;
  assign status_o.div_done  = div_done;
  assign status_o.root_done = root_done;
endmodule
`default_nettype wire

// File: hw/rtl/pws_ctrl.sv
// sequencer: accumulate, two divisions, square root, result hand-off
`default_nettype none
module pws_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_last_i,
  input  wire logic                 out_ready_i,
  input  wire pws_pkg::pws_status_t status_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  output pws_pkg::pws_cmd_t         cmd_o
);
  import pws_pkg::*;

  typedef enum logic [6:0] {
    ST_RUN     = 7'b0000001,
    ST_PREP    = 7'b0000010,
    ST_DIV_M   = 7'b0000100,
    ST_DIV_E   = 7'b0001000,
    ST_ROOT_GO = 7'b0010000,
    ST_ROOT    = 7'b0100000,
    ST_EMIT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_RUN: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && in_last_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        if (status_i.zero) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV_M;
        end
      end
      ST_DIV_M: begin
        if (status_i.div_done) begin
          cmd_o.latch_m   = 1'b1;
          cmd_o.sel_e     = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV_E;
        end
      end
      ST_DIV_E: begin
        cmd_o.sel_e = 1'b1;
        if (status_i.div_done) begin
          cmd_o.latch_e = 1'b1;
          state_d       = ST_ROOT_GO;
        end
      end
      ST_ROOT_GO: begin
        cmd_o.root_start = 1'b1;
        state_d          = ST_ROOT;
      end
      ST_ROOT: begin
        if (status_i.root_done) begin
          cmd_o.latch_root = 1'b1;
          state_d          = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  assign out_valid_d = cmd_o.emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_RUN);
  assign out_valid_o = out_valid_q;
endmodule
`default_nettype wire

// File: hw/rtl/pulse_window_statistics_top.sv
// top level of the pulse window statistics block
// Samples enter on the s_axis channel, one item per cycle while a window
// is open; tuser marks the first sample and tlast the last one of a window.
// A window also opens with the first sample after reset or after a result.
// Past 4096 samples further items are taken but ignored, tlast still closes.
// After the last item the block stops taking samples while it runs two
// divisions in the shared divider (centroid, second moment) and then a
// square root. A window whose sum is zero skips these and goes straight
// to the result.
// The result leaves on m_axis as one item through an output register;
// samples of the next window are accepted while it waits. If the receiver
// still holds the previous result when the next one is ready, the block
// waits with s_axis_tready low. area_scale is written by cfg_we_i; the user
// must write it only while idle, the block does not enforce this. Reset
// clears all windows and m_axis_tvalid, and sets area_scale to 65535.
`default_nettype none
`include "assert_macros.svh"
module pulse_window_statistics_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [15:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // sample[15:0], position[31:16]
  input  wire logic         s_axis_tuser,   // first
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // area[27:0], minimum_value[43:28], minimum_position[59:44],
  // maximum_value[75:60], maximum_position[91:76], before_maximum[107:92],
  // after_maximum[123:108], mean_time[148:124], time_spread[172:149], zero fill
  output logic [175:0]      m_axis_tdata,
  output logic              m_axis_tuser    // zero_sum
);
  import pws_pkg::*;

  pws_cmd_t    cmd;
  pws_status_t status;
  pws_result_t res;

  pws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  pws_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (s_axis_tdata[15:0]),
    .position_i  (s_axis_tdata[31:16]),
    .first_i     (s_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (res)
  );

  assign m_axis_tdata = {3'b000, res.spread, res.mean, res.after_max, res.before_max,
                         res.max_pos, res.max_val, res.min_pos, res.min_val, res.area};
  assign m_axis_tuser = res.zero;

  `PWS_ASSERT(a_last_closes, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
  `PWS_NEVER(a_accept_while_div, s_axis_tready && status.div_busy)
  `PWS_NEVER(a_div_restart, cmd.div_start && status.div_busy)
  `PWS_NEVER(a_emit_overwrite, cmd.emit && m_axis_tvalid && !m_axis_tready)
endmodule
`default_nettype wire

// File: bench/tb_pulse_window_statistics_top.sv
// testbench for the pulse window statistics block: predictor, stimulus, result checks
`timescale 1ns / 100ps
`default_nettype none
module tb_pulse_window_statistics_top;
  import pws_pkg::*;

  localparam int WINDOW_DEPTH = 4096;
  localparam int SETTLE_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1600;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [15:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [175:0] m_axis_tdata;
  logic         m_axis_tuser;

  pulse_window_statistics_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct {
    logic signed [15:0] sample;
    logic [15:0]        position;
    logic               first;
    logic               last;
  } sample_item_t;

  // predictor state
  logic [15:0]    scale_q;
  longint         sum_acc, w1_acc, w2_acc;
  longint         lo_val, hi_val, before_pk, after_pk, prev_smp;
  int unsigned    lo_pos, hi_pos, win_idx, win_start;
  bit             after_wait;

  pws_result_t    stats_expected[$];
  int             error_count = 0;
  int             results_seen = 0;
  int             windows_sent = 0;
  int             items_sent = 0;
  int             idle_cycles = 0;

  function automatic void clear_window();
    sum_acc = 0; w1_acc = 0; w2_acc = 0;
    lo_val = 32767; hi_val = -32768;
    lo_pos = 0; hi_pos = 0;
    before_pk = 0; after_pk = 0; after_wait = 1'b0;
    prev_smp = 0; win_idx = 0; win_start = 0;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint div_round(longint n, longint d);
    longint un, ud, q;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = (un + ud / 2) / ud;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // feeds one sample through the predictor; returns 1 when a window closes
  function automatic bit predict_sample(sample_item_t it, output pws_result_t r);
    longint s, k, lim52, sa, prod, area, m8, e2, mc, v;
    longint unsigned uv, spread;
    s = it.sample;
    lim52 = 64'sd1 <<< 52;
    r = '0;
    if (it.first) clear_window();
    if (win_idx < WINDOW_DEPTH) begin
      k = win_idx;
      if (k == 0) win_start = it.position;
      sum_acc += s;
      w1_acc += k * s;
      w2_acc += k * k * s;
      if (k == 0 || s < lo_val) begin
        lo_val = s; lo_pos = it.position;
      end
      if (k == 0 || s > hi_val) begin
        hi_val = s; hi_pos = it.position;
        before_pk = (k == 0) ? 0 : prev_smp;
        after_pk = 0; after_wait = 1'b1;
      end else if (after_wait) begin
        after_pk = s; after_wait = 1'b0;
      end
      prev_smp = s;
      win_idx++;
    end
    if (!it.last) return 1'b0;
    sa = clip(sum_acc, -lim52, lim52);
    prod = (sa < 0 ? -sa : sa) * longint'(scale_q);
    area = sa < 0 ? -((prod + 65535) >>> 16) : (prod >>> 16);
    area = clip(area, -(64'sd1 <<< 27), (64'sd1 <<< 27) - 1);
    r.area = area[27:0];
    r.min_val = lo_val[15:0];
    r.min_pos = lo_pos[15:0];
    r.max_val = hi_val[15:0];
    r.max_pos = hi_pos[15:0];
    r.before_max = before_pk[15:0];
    r.after_max = after_pk[15:0];
    if (sum_acc == 0) begin
      r.zero = 1'b1;
    end else begin
      m8 = div_round(clip(w1_acc, -lim52, lim52) * 256, sum_acc);
      e2 = clip(div_round(clip(w2_acc, -lim52, lim52) * 256, sum_acc), -lim52, lim52);
      mc = clip(m8, -(64'sd1 <<< 26), 64'sd1 <<< 26);
      v = e2 * 256 - mc * mc;
      uv = v < 0 ? -v : v;
      spread = int_sqrt(uv);
      if (spread > 64'hFFFFFF) spread = 64'hFFFFFF;
      r.spread = spread[23:0];
      v = clip(longint'(win_start) * 256 + m8, -(64'sd1 <<< 24), (64'sd1 <<< 24) - 1);
      r.mean = v[24:0];
    end
    clear_window();
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch in result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    error_count++;
  endtask

  // gaps: mostly none or short, occasionally long
  function automatic int gap_length();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // tvalid stays high after an accepted item until the next item or a gap
  task automatic send_item(sample_item_t it);
    pws_result_t r;
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {it.position, it.sample};
    s_axis_tuser <= it.first;
    s_axis_tlast <= it.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (predict_sample(it, r)) begin
      stats_expected = {stats_expected, r};
      windows_sent++;
    end
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (stats_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scale(logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scale_q = value;
  endtask

  task automatic send_window(int len, int kind, logic [15:0] pos0);
    sample_item_t it;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: it.sample = 16'($urandom());
        1: it.sample = 16'($urandom_range(2000));
        2: it.sample = (i % 2) ? 16'sd100 : -16'sd100;
        default: it.sample = 16'($urandom_range(7) - 3);
      endcase
      it.position = 16'(pos0 + i);
      it.first = (i == 0);
      it.last = (i == len - 1);
      send_item(it);
    end
  endtask

  // receiver with random stalls
  initial begin
    pws_result_t got, want;
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = gap_length();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got = '0;
      got.area = m_axis_tdata[27:0];
      got.min_val = m_axis_tdata[43:28];
      got.min_pos = m_axis_tdata[59:44];
      got.max_val = m_axis_tdata[75:60];
      got.max_pos = m_axis_tdata[91:76];
      got.before_max = m_axis_tdata[107:92];
      got.after_max = m_axis_tdata[123:108];
      got.mean = m_axis_tdata[148:124];
      got.spread = m_axis_tdata[172:149];
      got.zero = m_axis_tuser;
      results_seen++;
      if (stats_expected.size() == 0) begin
        $display("unexpected result %0d", results_seen);
        error_count++;
      end else begin
        want = stats_expected.pop_front();
        if (got.area != want.area) report_mismatch("area", got.area, want.area);
        if (got.min_val != want.min_val)
          report_mismatch("minimum_value", got.min_val, want.min_val);
        if (got.min_pos != want.min_pos)
          report_mismatch("minimum_position", got.min_pos, want.min_pos);
        if (got.max_val != want.max_val)
          report_mismatch("maximum_value", got.max_val, want.max_val);
        if (got.max_pos != want.max_pos)
          report_mismatch("maximum_position", got.max_pos, want.max_pos);
        if (got.before_max != want.before_max)
          report_mismatch("before_maximum", got.before_max, want.before_max);
        if (got.after_max != want.after_max)
          report_mismatch("after_maximum", got.after_max, want.after_max);
        if (got.mean != want.mean) report_mismatch("mean_time", got.mean, want.mean);
        if (got.spread != want.spread)
          report_mismatch("time_spread", got.spread, want.spread);
        if (got.zero != want.zero) report_mismatch("zero_sum", got.zero, want.zero);
      end
    end
  end

  // watchdog on cycles without any accepted item or configuration write
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("tb_pulse_window_statistics_top: errors");
      $finish;
    end
  end

  // directed rows: {sample, position, first, last}, typed value checks where trivial
  typedef struct {
    logic signed [15:0] sample;
    logic [15:0]        position;
    logic               first;
    logic               last;
  } row_t;

  row_t directed_rows[] = '{
    '{16'sh7FFF, 16'd0, 1'b1, 1'b1},          // single sample at max
    '{-16'sh8000, 16'hFFFF, 1'b1, 1'b1},      // single sample at min
    '{16'sd0, 16'd10, 1'b1, 1'b1},            // zero sum, single
    '{16'sd5, 16'd20, 1'b0, 1'b0},            // no first flag opens window
    '{-16'sd5, 16'd21, 1'b0, 1'b1},           // zero sum over two
    '{16'sd3, 16'd30, 1'b1, 1'b0},
    '{16'sd9, 16'd31, 1'b0, 1'b0},            // peak in middle
    '{16'sd9, 16'd32, 1'b0, 1'b0},            // tie, first wins
    '{16'sd1, 16'd33, 1'b0, 1'b1},
    '{16'sd7, 16'd40, 1'b1, 1'b0},            // dropped by later first
    '{16'sd1, 16'd50, 1'b1, 1'b0},
    '{16'sd2, 16'd51, 1'b0, 1'b0},
    '{16'sh7FFF, 16'd52, 1'b0, 1'b1},         // peak last
    '{-16'sd1, 16'hFFFE, 1'b1, 1'b0},
    '{16'sd2, 16'hFFFF, 1'b0, 1'b1},          // mean saturates high
    '{-16'sd100, 16'd60, 1'b1, 1'b0},
    '{16'sd30, 16'd61, 1'b0, 1'b0},
    '{-16'sd20, 16'd62, 1'b0, 1'b1}           // negative sum
  };

  initial begin
    sample_item_t it;
    pws_result_t r;
    logic [15:0] scales[4];
    scales = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001};
    clear_window();
    scale_q = 16'hFFFF;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      it.sample = directed_rows[i].sample;
      it.position = directed_rows[i].position;
      it.first = directed_rows[i].first;
      it.last = directed_rows[i].last;
      send_item(it);
      // one-sample extremes have fixed results
      if (i == 0 && (stats_expected[$].max_val != 16'sh7FFF || stats_expected[$].spread != 0))
        report_mismatch("table row max", stats_expected[$].max_val, 32767);
      if (i == 1 && stats_expected[$].min_pos != 16'hFFFF)
        report_mismatch("table row min", stats_expected[$].min_pos, 65535);
      if (i == 2 && stats_expected[$].zero != 1'b1)
        report_mismatch("table row zero", stats_expected[$].zero, 1);
    end

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_scale(scales[ph]);
      while (items_sent < directed_rows.size() + (ph + 1) * RANDOM_ITEMS / 4) begin
        int sel;
        sel = $urandom_range(99);
        if (sel < 80) begin
          send_window($urandom_range(24, 1), $urandom_range(3), 16'($urandom()));
        end else begin
          // noise: loose flags
          it.sample = 16'($urandom());
          it.position = 16'($urandom());
          it.first = 1'($urandom_range(1));
          it.last = ($urandom_range(3) == 0);
          send_item(it);
        end
      end
    end
    // close any open window
    it.sample = 16'($urandom()); it.position = 0; it.first = 1'b0; it.last = 1'b1;
    send_item(it);
    wait_drained();

    $display("sent %0d samples in %0d windows, checked %0d results over 4 scale settings",
             items_sent, windows_sent, results_seen);
    if (error_count == 0)
      $display("tb_pulse_window_statistics_top: clean");
    else
      $display("tb_pulse_window_statistics_top: errors");
    $finish;
  end
endmodule
`default_nettype wire
